[hdl/mhsic_pkg.sv]
package mhsic_pkg;

  localparam int SW = 20;               // scaled / result width
  localparam int PW = 38;               // shared multiplier product width (21 x 17)

  localparam logic signed [PW-1:0] SMAX = (PW'(1) <<< (SW - 1)) - PW'(1);
  localparam logic signed [PW-1:0] SMIN = -SMAX - PW'(1);

  localparam logic [1:0] REQ_CORRECT = 2'd0;
  localparam logic [1:0] REQ_START   = 2'd1;
  localparam logic [1:0] REQ_SAMPLE  = 2'd2;
  localparam logic [1:0] REQ_RAW     = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DISABLED = 3'd1;
  localparam logic [2:0] ST_ABSORBED = 3'd2;
  localparam logic [2:0] ST_DONE     = 3'd3;
  localparam logic [2:0] ST_ZERO     = 3'd4;
  localparam logic [2:0] ST_IGNORED  = 3'd5;

  localparam logic [2:0] CFG_ENABLE = 3'd0;
  localparam logic [2:0] CFG_GAIN_X = 3'd1;
  localparam logic [2:0] CFG_GAIN_Y = 3'd2;
  localparam logic [2:0] CFG_GAIN_Z = 3'd3;
  localparam logic [2:0] CFG_RANGE  = 3'd4;
  localparam logic [2:0] CFG_COUNT  = 3'd5;

  localparam logic [15:0] UNITY_Q14 = 16'd16384;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [15:0] mag_x;
    logic signed [15:0] mag_y;
    logic signed [15:0] mag_z;
  } in_t;

  typedef struct packed {
    logic [2:0]           status;
    logic signed [SW-1:0] out_x;
    logic signed [SW-1:0] out_y;
    logic signed [SW-1:0] out_z;
    logic                 calibrated;
  } out_t;

  // Clamp a wide signed value to the scaled range.
  function automatic logic signed [SW-1:0] sat_sw(input logic signed [PW-1:0] v);
    logic signed [SW-1:0] r;
    if (v > SMAX) begin
      r = SMAX[SW-1:0];
    end else if (v < SMIN) begin
      r = SMIN[SW-1:0];
    end else begin
      r = v[SW-1:0];
    end
    return r;
  endfunction

endpackage

[hdl/mhsic_div.sv]
module mhsic_div
  import mhsic_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [SW:0]   sum,
  input  logic [SW-2:0] dlt,
  output logic          busy,
  output logic          done,
  output logic [15:0]   quot
);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [4:0]    cnt_r, cnt_nxt;
  logic [SW:0]   rem_r, rem_nxt;
  logic [SW:0]   den_r, den_nxt;
  logic [15:0]   lo_r, lo_nxt;
  logic [15:0]   q_r, q_nxt;
  logic [SW+2:0] dlt12;
  logic [SW+1:0] trial;
  logic          ge;

  // Quotient of (sum << 14) / (3 * dlt), saturated to 16 bits.
  assign dlt12 = {2'b00, dlt, 2'b00} + {1'b0, dlt, 3'b000};
  assign trial = {rem_r, lo_r[15]};
  assign ge    = trial >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    lo_nxt   = lo_r;
    q_nxt    = q_r;
    if (start) begin
      if ({2'b00, sum} >= dlt12) begin
        q_nxt    = 16'hFFFF;
        done_nxt = 1'b1;
      end else begin
        rem_nxt  = {2'b00, sum[SW:2]};
        den_nxt  = {2'b00, dlt} + {1'b0, dlt, 1'b0};
        lo_nxt   = {sum[1:0], 14'd0};
        cnt_nxt  = 5'd16;
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      rem_nxt = ge ? (SW+1)'(trial - {1'b0, den_r}) : trial[SW:0];
      q_nxt   = {q_r[14:0], ge};
      lo_nxt  = {lo_r[14:0], 1'b0};
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    lo_r  <= lo_nxt;
    q_r   <= q_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = q_r;

endmodule

[hdl/mag_hard_soft_iron_calibrate.sv]
// Magnetometer hard/soft-iron calibration and correction.
// Input channel (in_valid/in_ready/in_data) takes one request transaction:
// correct, start calibration, calibration sample or raw scaled sample.
// Output channel (out_valid/out_ready/out_data) returns exactly one result
// transaction per request. Configuration (cfg_we/cfg_index/cfg_wdata) is a
// plain write port that the user must use only while the block is idle; the
// block does not enforce this. One item at a time: in_ready is high only in
// the idle state. Each axis is scaled by one shared 21x17 multiplier. The
// sample that ends a run adds offset/span setup and up to three quotients
// in the 16-step iterative divider.
// The result sits in an output register; while the receiver stalls the block
// still accepts the next request and holds it before emission until the
// register frees. Reset (synchronous, active low) restores register
// defaults, unity scales, zero offsets and clears the calibration flags.
module mag_hard_soft_iron_calibrate
  import mhsic_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [18:0] cfg_wdata
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL  = 4'd1;
  localparam logic [3:0] S_SAT  = 4'd2;
  localparam logic [3:0] S_DISP = 4'd3;
  localparam logic [3:0] S_CMUL = 4'd4;
  localparam logic [3:0] S_CSAT = 4'd5;
  localparam logic [3:0] S_FIN  = 4'd6;
  localparam logic [3:0] S_SUM  = 4'd7;
  localparam logic [3:0] S_DIVS = 4'd8;
  localparam logic [3:0] S_DIVW = 4'd9;
  localparam logic [3:0] S_EMIT = 4'd10;

  // configuration
  logic        enable_r;
  logic [15:0] gain_r [3];
  logic [18:0] range_r;
  logic [15:0] count_r;

  // calibration state
  logic signed [SW-1:0] max_r [3];
  logic signed [SW-1:0] min_r [3];
  logic signed [SW-1:0] off_r [3];
  logic [15:0]          scale_r [3];
  logic [SW-2:0]        dlt_r [3];
  logic [SW:0]          sum_r;
  logic [15:0]          taken_r;
  logic                 active_r;
  logic                 cal_done_r;
  logic                 zero_r;

  // working state
  logic [3:0]           state_r;
  logic [1:0]           idx_r;
  logic [1:0]           req_r;
  logic signed [15:0]   raw_r [3];
  logic signed [SW-1:0] s_r [3];
  logic signed [PW-1:0] prod_r;
  logic [2:0]           status_r;
  logic signed [SW-1:0] res_x_r, res_y_r, res_z_r;
  logic                 out_valid_r;
  out_t                 out_data_r;

  logic signed [SW:0]   mul_a;
  logic signed [16:0]   mul_b;
  logic signed [SW-1:0] sat_val;
  logic signed [SW-1:0] neg_val;
  logic signed [SW-1:0] rng;
  logic [15:0]          taken_inc;
  logic                 slot_free;
  logic                 div_start, div_busy, div_done;
  logic [15:0]          div_quot;
  logic                 axis_zero;

  assign in_ready  = (state_r == S_IDLE);
  assign slot_free = !out_valid_r || out_ready;
  assign taken_inc = taken_r + 16'd1;
  // mag_range never exceeds the 20-bit positive limit, so no clamp binds
  assign rng       = {1'b0, range_r};

  // shared multiplier operands: gain scaling or offset/scale correction
  always_comb begin
    if (state_r == S_CMUL) begin
      mul_a = {s_r[idx_r][SW-1], s_r[idx_r]} - {off_r[idx_r][SW-1], off_r[idx_r]};
      mul_b = {1'b0, scale_r[idx_r]};
    end else begin
      mul_a = (SW+1)'(raw_r[idx_r]);
      mul_b = {1'b0, gain_r[idx_r]};
    end
  end

  assign sat_val   = (state_r == S_CSAT) ? sat_sw(prod_r >>> 14) : sat_sw(prod_r >>> 12);
  assign neg_val   = (sat_val == SMIN[SW-1:0]) ? SMAX[SW-1:0] : -sat_val;
  assign axis_zero = (dlt_r[idx_r] == '0);
  assign div_start = (state_r == S_DIVS) && !axis_zero;

  mhsic_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .sum   (sum_r),
    .dlt   (dlt_r[idx_r]),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b0;
      gain_r[0]   <= 16'd4096;
      gain_r[1]   <= 16'd4096;
      gain_r[2]   <= 16'd4096;
      range_r     <= 19'd524287;
      count_r     <= 16'd1000;
      for (int i = 0; i < 3; i++) begin
        max_r[i]   <= '0;
        min_r[i]   <= '0;
        off_r[i]   <= '0;
        scale_r[i] <= UNITY_Q14;
      end
      taken_r     <= '0;
      active_r    <= 1'b0;
      cal_done_r  <= 1'b0;
      zero_r      <= 1'b0;
      state_r     <= S_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ENABLE: enable_r  <= cfg_wdata[0];
          CFG_GAIN_X: gain_r[0] <= cfg_wdata[15:0];
          CFG_GAIN_Y: gain_r[1] <= cfg_wdata[15:0];
          CFG_GAIN_Z: gain_r[2] <= cfg_wdata[15:0];
          CFG_RANGE:  range_r   <= cfg_wdata;
          CFG_COUNT:  count_r   <= cfg_wdata[15:0];
          default: ;
        endcase
      end

      // raise the result on emission, drop it once taken
      if (state_r == S_EMIT && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            req_r    <= in_data.req_type;
            raw_r[0] <= in_data.mag_x;
            raw_r[1] <= in_data.mag_y;
            raw_r[2] <= in_data.mag_z;
            idx_r    <= '0;
            if (!enable_r) begin
              status_r <= ST_DISABLED;
              res_x_r  <= '0;
              res_y_r  <= '0;
              res_z_r  <= '0;
              state_r  <= S_EMIT;
            end else begin
              state_r <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod_r  <= mul_a * mul_b;
          state_r <= S_SAT;
        end
        S_SAT: begin
          s_r[idx_r] <= sat_val;
          if (idx_r == 2'd2) begin
            idx_r   <= '0;
            state_r <= S_DISP;
          end else begin
            idx_r   <= idx_r + 2'd1;
            state_r <= S_MUL;
          end
        end
        S_DISP: begin
          res_x_r  <= s_r[0];
          res_y_r  <= s_r[1];
          res_z_r  <= s_r[2];
          status_r <= ST_OK;
          state_r  <= S_EMIT;
          case (req_r)
            REQ_CORRECT: begin
              state_r <= S_CMUL;
            end
            REQ_START: begin
              for (int i = 0; i < 3; i++) begin
                max_r[i] <= -rng;
                min_r[i] <= rng;
              end
              taken_r  <= '0;
              active_r <= 1'b1;
              res_x_r  <= '0;
              res_y_r  <= '0;
              res_z_r  <= '0;
            end
            REQ_SAMPLE: begin
              if (!active_r) begin
                status_r <= ST_IGNORED;
                res_x_r  <= '0;
                res_y_r  <= '0;
                res_z_r  <= '0;
              end else begin
                for (int i = 0; i < 3; i++) begin
                  if (s_r[i] > max_r[i]) max_r[i] <= s_r[i];
                  if (s_r[i] < min_r[i]) min_r[i] <= s_r[i];
                end
                taken_r  <= taken_inc;
                status_r <= ST_ABSORBED;
                if (taken_inc >= count_r) begin
                  state_r <= S_FIN;
                end
              end
            end
            default: ;
          endcase
        end
        S_CMUL: begin
          prod_r  <= mul_a * mul_b;
          state_r <= S_CSAT;
        end
        S_CSAT: begin
          s_r[idx_r] <= sat_val;
          if (idx_r == 2'd2) begin
            // swap x and y, negate z
            res_x_r <= s_r[1];
            res_y_r <= s_r[0];
            res_z_r <= neg_val;
            state_r <= S_EMIT;
          end else begin
            idx_r   <= idx_r + 2'd1;
            state_r <= S_CMUL;
          end
        end
        S_FIN: begin
          for (int i = 0; i < 3; i++) begin
            logic signed [SW:0] sm;
            logic signed [SW:0] df;
            sm = {max_r[i][SW-1], max_r[i]} + {min_r[i][SW-1], min_r[i]};
            df = {max_r[i][SW-1], max_r[i]} - {min_r[i][SW-1], min_r[i]};
            off_r[i] <= sm[SW:1];
            dlt_r[i] <= df[SW] ? '0 : df[SW-1:1];
          end
          state_r <= S_SUM;
        end
        S_SUM: begin
          sum_r   <= {2'b00, dlt_r[0]} + {2'b00, dlt_r[1]} + {2'b00, dlt_r[2]};
          zero_r  <= 1'b0;
          idx_r   <= '0;
          state_r <= S_DIVS;
        end
        S_DIVS, S_DIVW: begin
          if ((state_r == S_DIVS && axis_zero) || (state_r == S_DIVW && div_done)) begin
            scale_r[idx_r] <= axis_zero ? UNITY_Q14 : div_quot;
            zero_r         <= zero_r | axis_zero;
            if (idx_r == 2'd2) begin
              active_r   <= 1'b0;
              cal_done_r <= 1'b1;
              status_r   <= (zero_r || axis_zero) ? ST_ZERO : ST_DONE;
              state_r    <= S_EMIT;
            end else begin
              idx_r   <= idx_r + 2'd1;
              state_r <= S_DIVS;
            end
          end else begin
            state_r <= S_DIVW;
          end
        end
        S_EMIT: begin
          // hold until the output register frees
          if (slot_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
    if (state_r == S_EMIT && slot_free) begin
      out_data_r.status     <= status_r;
      out_data_r.out_x      <= res_x_r;
      out_data_r.out_y      <= res_y_r;
      out_data_r.out_z      <= res_z_r;
      out_data_r.calibrated <= cal_done_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r != S_IDLE)
    else $error("block idle right after accepting a request");

  a_div_start_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_cal_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !$fell(cal_done_r))
    else $error("calibration flag cleared outside reset");
`endif

endmodule
